FILE: design/bif_pkg.sv
// shared types and constants of the bracket indent formatter
`timescale 1ns / 1ps

package bif_pkg;

    // character codes
    localparam logic [7:0] CHR_LBRACE = 8'h7B;
    localparam logic [7:0] CHR_LPAREN = 8'h28;
    localparam logic [7:0] CHR_LBRACK = 8'h5B;
    localparam logic [7:0] CHR_RBRACE = 8'h7D;
    localparam logic [7:0] CHR_RPAREN = 8'h29;
    localparam logic [7:0] CHR_RBRACK = 8'h5D;
    localparam logic [7:0] CHR_COMMA  = 8'h2C;
    localparam logic [7:0] CHR_SEMI   = 8'h3B;
    localparam logic [7:0] CHR_DQUOTE = 8'h22;
    localparam logic [7:0] CHR_SQUOTE = 8'h27;
    localparam logic [7:0] CHR_NEWLINE = 8'h0A;

    // indent width register
    localparam logic [3:0] INDENT_WIDTH_RESET = 4'd4;
    localparam logic [3:0] INDENT_WIDTH_MAX   = 4'd8;
    localparam logic       ADDR_INDENT_WIDTH  = 1'b0;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // what the back end has to do with one byte
    typedef enum logic [1:0] {
        CLS_PASS,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_SEP
    } cls_t;

    // one classified request
    typedef struct packed {
        cls_t       cls;
        logic [7:0] data;
        logic [7:0] depth_a;   // depth of the first line break
        logic [7:0] depth_b;   // depth of the break after an opening bracket
    } cmd_t;

endpackage

FILE: design/bif_front.sv
// front end: accepts bytes, tracks quotes and nesting depth, classifies
`timescale 1ns / 1ps

module bif_front import bif_pkg::*; #(
    parameter int MAX_DEPTH = 255
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // in_byte[7:0]
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    typedef enum logic [1:0] {
        Q_NONE,
        Q_DOUBLE,
        Q_SINGLE,
        Q_STRAY
    } quote_t;

    localparam logic [7:0] DEPTH_LIMIT = 8'(MAX_DEPTH);

    logic [7:0] depth_reg, depth_next;
    quote_t     quote_reg, quote_next;
    logic       accept;
    quote_t     byte_quote;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;

    // classify the byte and work out the next depth and quote state
    always_comb begin
        depth_next    = depth_reg;
        quote_next    = quote_reg;
        q_cmd.cls     = CLS_PASS;
        q_cmd.data    = s_tdata;
        q_cmd.depth_a = depth_reg;
        q_cmd.depth_b = depth_reg;
        byte_quote    = (s_tdata == CHR_DQUOTE) ? Q_DOUBLE : Q_SINGLE;

        if (s_tdata == CHR_DQUOTE || s_tdata == CHR_SQUOTE) begin
            // a quote of the other kind leaves the open one alone
            if (quote_reg == Q_NONE || quote_reg == Q_STRAY) begin
                quote_next = byte_quote;
            end else if (quote_reg == byte_quote) begin
                quote_next = Q_NONE;
            end
        end else if (quote_reg == Q_DOUBLE || quote_reg == Q_SINGLE) begin
            q_cmd.cls = CLS_PASS;
        end else begin
            unique case (s_tdata) inside
                CHR_LBRACE, CHR_LPAREN, CHR_LBRACK: begin
                    q_cmd.cls = CLS_OPEN;
                    if (depth_reg < DEPTH_LIMIT) begin
                        depth_next = depth_reg + 8'd1;
                    end
                    q_cmd.depth_b = depth_next;
                end
                CHR_RBRACE, CHR_RPAREN, CHR_RBRACK: begin
                    q_cmd.cls = CLS_CLOSE;
                    if (depth_reg != 8'd0) begin
                        depth_next = depth_reg - 8'd1;
                    end
                    q_cmd.depth_a = depth_next;
                end
                CHR_COMMA, CHR_SEMI: begin
                    q_cmd.cls = CLS_SEP;
                end
                default: begin
                    q_cmd.cls = CLS_PASS;
                end
            endcase
        end
    end

    // state update on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
            quote_reg <= Q_NONE;
        end else if (accept) begin
            depth_reg <= depth_next;
            quote_reg <= quote_next;
        end
    end

`ifndef NO_ASSERTIONS
    // depth never passes the configured ceiling
    a_depth_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_LIMIT)
        else $error("nesting depth above limit");
`endif

endmodule

FILE: design/bif_queue.sv
// short command queue between the front and back ends
`timescale 1ns / 1ps

module bif_queue import bif_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    localparam logic [QCNT_W-1:0] COUNT_FULL = QCNT_W'(QUEUE_DEPTH);
    localparam logic [QPTR_W-1:0] PTR_LAST   = QPTR_W'(QUEUE_DEPTH - 1);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == COUNT_FULL);
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_FULL)
        else $error("queue count out of range");
`endif

endmodule

FILE: design/bif_back.sv
// back end: expands each command into results, one per cycle while m_tready is high
`timescale 1ns / 1ps

module bif_back import bif_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [3:0]  indent_width,
    input  logic        q_empty,
    input  cmd_t        q_head,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // out_byte[7:0], indent_spaces[18:8], zero pad
    output logic [0:0]  m_tuser,    // kind[0]
    output logic        m_tlast
);

    logic [1:0]  step_reg, step_next;
    logic        valid_reg, valid_next;
    logic        kind_reg;
    logic [7:0]  byte_reg;
    logic [10:0] spaces_reg;
    logic        last_reg;

    logic        load;
    logic        is_break;
    logic        is_last;
    logic [7:0]  brk_depth;
    logic [3:0]  eff_width;
    logic [11:0] product;
    logic [10:0] spaces;

    // which result of the head command this step produces
    always_comb begin
        is_break  = 1'b0;
        is_last   = 1'b1;
        brk_depth = q_head.depth_a;
        case (q_head.cls)
            CLS_OPEN: begin
                is_break  = (step_reg != 2'd1);
                is_last   = (step_reg == 2'd2);
                brk_depth = (step_reg == 2'd2) ? q_head.depth_b : q_head.depth_a;
            end
            CLS_CLOSE: begin
                is_break = (step_reg == 2'd0);
                is_last  = (step_reg == 2'd1);
            end
            CLS_SEP: begin
                is_break = (step_reg == 2'd1);
                is_last  = (step_reg == 2'd1);
            end
            default: begin
                is_break = 1'b0;
                is_last  = 1'b1;
            end
        endcase
    end

    // indent count, width clamped to eight
    assign eff_width = (indent_width > INDENT_WIDTH_MAX) ? INDENT_WIDTH_MAX : indent_width;
    assign product   = {4'd0, brk_depth} * {8'd0, eff_width};
    assign spaces    = product[10:0];

    // output register takes a new result when empty or drained
    assign load  = (!valid_reg || m_tready) && !q_empty;
    assign q_pop = load && is_last;

    always_comb begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            step_next  = is_last ? 2'd0 : step_reg + 2'd1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg   <= is_break;
            byte_reg   <= is_break ? CHR_NEWLINE : q_head.data;
            spaces_reg <= is_break ? spaces : 11'd0;
            last_reg   <= is_last;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = {5'd0, spaces_reg, byte_reg};
    assign m_tuser[0] = kind_reg;
    assign m_tlast    = last_reg;

`ifndef NO_ASSERTIONS
    // a command part way through expansion is still at the queue head
    a_step_has_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_empty && step_reg != 2'd0))
        else $error("expansion step without a command");
`endif

endmodule

FILE: design/bracket_indent_formatter_unit.sv
// top level of the bracket indent formatter
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  s_tdata: in_byte
//  m_*       out        m_tvalid/m_tready  m_tdata: out_byte, indent_spaces;
//                                          m_tuser: kind; m_tlast: last
//  apb       in         psel/penable       indent_width at byte address 0
//
// a byte is taken each cycle while the four-entry command queue has room
// results leave one per cycle while m_tready is high, and a byte yields 1 to 3 results
// (3 for an opening bracket, 2 for a closing bracket or separator, else 1)
// reset is synchronous and active low; it clears depth, quote state and queue,
// and sets indent_width to 4; there is no clearing pass
// a stalled result port fills the queue and then deasserts s_tready
`timescale 1ns / 1ps

module bracket_indent_formatter_unit import bif_pkg::*; #(
    parameter int MAX_DEPTH = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // in_byte[7:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // out_byte[7:0], indent_spaces[18:8], zero pad
    output logic [0:0]  m_tuser,    // kind[0]
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0] indent_width_reg;
    logic       cfg_write;
    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    cmd_t       push_cmd;
    cmd_t       q_head;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == ADDR_INDENT_WIDTH);
    assign prdata    = (paddr[2] == ADDR_INDENT_WIDTH) ? {28'd0, indent_width_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            indent_width_reg <= INDENT_WIDTH_RESET;
        end else if (cfg_write) begin
            indent_width_reg <= pwdata[3:0];
        end
    end

    bif_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    bif_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    bif_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .indent_width (indent_width_reg),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule
